/* sv/lssp_pkg.sv */
// Shared types, constants and helper functions of the link-state shortest-path block.
// Used by lssp_ctrl, lssp_dp and the top level; depends on nothing else.
`default_nettype none

package lssp_pkg;

    // Node count and derived widths.
    localparam int NODES     = 16;
    localparam int IDX_W     = $clog2(NODES);
    localparam int MAT_DEPTH = NODES * NODES;
    localparam int MAT_AW    = $clog2(MAT_DEPTH);

    // Field widths of the stream beats.
    localparam int NODE_W = 4;
    localparam int COST_W = 10;
    localparam int DIST_W = 10;
    localparam int PICK_W = 14;

    // Input tdata layout, lowest field first.
    localparam int A_LO       = 0;
    localparam int B_LO       = A_LO + NODE_W;
    localparam int COST_LO    = B_LO + NODE_W;
    localparam int SRC_LO     = COST_LO + COST_W;
    localparam int S_FIELDS_W = SRC_LO + NODE_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

    // Output tdata layout, lowest field first.
    localparam int IDX_LO     = 0;
    localparam int DIST_LO    = IDX_LO + NODE_W;
    localparam int M_FIELDS_W = DIST_LO + DIST_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [DIST_W-1:0] UNREACHABLE = DIST_W'(1000);
    localparam logic [PICK_W-1:0] PICK_LIMIT  = PICK_W'(10000);
    localparam logic [IDX_W-1:0]  LAST_IDX    = IDX_W'(NODES - 1);
    localparam logic [IDX_W-1:0]  LAST_ROUND  = IDX_W'(NODES - 2);
    localparam logic [MAT_AW-1:0] LAST_ADDR   = MAT_AW'(MAT_DEPTH - 1);

    // Request kinds carried in tuser.
    localparam logic REQ_UPDATE  = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_PASS,
        ST_DRAIN,
        ST_OUTPUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              clr_we;
        logic [MAT_AW-1:0] clr_addr;
        logic              upd_ab;
        logic              upd_ba;
        logic              start;
        logic              issue;
        logic [IDX_W-1:0]  k;
        logic              out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_sts;

    function automatic logic node_ok(input logic [NODE_W-1:0] n);
        return ({1'b0, n} < (NODE_W + 1)'(NODES));
    endfunction

    function automatic logic [MAT_AW-1:0] mat_addr(input logic [IDX_W-1:0] row,
                                                   input logic [IDX_W-1:0] col);
        return MAT_AW'(row) * MAT_AW'(NODES) + MAT_AW'(col);
    endfunction

endpackage

`default_nettype wire

/* sv/lssp_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; no package needed.
`default_nettype none

module lssp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* sv/lssp_ctrl.sv */
// Controller of the shortest-path block: state machine, sweep and round counters.
// Depends on lssp_pkg; drives the datapath through lssp_pkg::t_cmd.
`default_nettype none

module lssp_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_kind,
    output logic               o_in_ready,
    input  wire lssp_pkg::t_sts i_sts,
    output lssp_pkg::t_cmd     o_cmd
);

    lssp_pkg::t_state r_state, n_state;
    logic [lssp_pkg::MAT_AW-1:0] r_clr, n_clr;
    logic [lssp_pkg::IDX_W-1:0]  r_k, n_k;
    logic [lssp_pkg::IDX_W-1:0]  r_round, n_round;
    logic                        accept;

    assign accept = (r_state == lssp_pkg::ST_IDLE) && i_in_valid;

    // Next state and counters.
    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_k     = r_k;
        n_round = r_round;
        case (r_state)
            lssp_pkg::ST_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == lssp_pkg::LAST_ADDR) begin
                    n_state = lssp_pkg::ST_IDLE;
                end
            end
            lssp_pkg::ST_IDLE: begin
                if (accept) begin
                    n_k     = '0;
                    n_round = '0;
                    if (i_in_kind == lssp_pkg::REQ_COMPUTE) begin
                        n_state = lssp_pkg::ST_PASS;
                    end else begin
                        n_state = lssp_pkg::ST_UPDATE;
                    end
                end
            end
            lssp_pkg::ST_UPDATE: begin
                n_state = lssp_pkg::ST_IDLE;
            end
            lssp_pkg::ST_PASS: begin
                if (r_k == lssp_pkg::LAST_IDX) begin
                    n_k     = '0;
                    n_state = lssp_pkg::ST_DRAIN;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            lssp_pkg::ST_DRAIN: begin
                if (r_round == lssp_pkg::LAST_ROUND) begin
                    n_state = lssp_pkg::ST_OUTPUT;
                end else begin
                    n_round = r_round + 1'b1;
                    n_state = lssp_pkg::ST_PASS;
                end
            end
            lssp_pkg::ST_OUTPUT: begin
                if (i_sts.out_free) begin
                    if (r_k == lssp_pkg::LAST_IDX) begin
                        n_k     = '0;
                        n_state = lssp_pkg::ST_IDLE;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            default: begin
                n_state = lssp_pkg::ST_CLEAR;
                n_clr   = '0;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_in_ready     = (r_state == lssp_pkg::ST_IDLE);
        o_cmd          = '0;
        o_cmd.clr_addr = r_clr;
        o_cmd.k        = r_k;
        case (r_state)
            lssp_pkg::ST_CLEAR: begin
                o_cmd.clr_we = 1'b1;
            end
            lssp_pkg::ST_IDLE: begin
                o_cmd.upd_ab = accept && (i_in_kind == lssp_pkg::REQ_UPDATE);
                o_cmd.start  = accept && (i_in_kind == lssp_pkg::REQ_COMPUTE);
            end
            lssp_pkg::ST_UPDATE: begin
                o_cmd.upd_ba = 1'b1;
            end
            lssp_pkg::ST_PASS: begin
                o_cmd.issue = 1'b1;
            end
            lssp_pkg::ST_OUTPUT: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_cmd.clr_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lssp_pkg::ST_CLEAR;
            r_clr   <= '0;
            r_k     <= '0;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_k     <= n_k;
            r_round <= n_round;
        end
    end

endmodule

`default_nettype wire

/* sv/lssp_dp.sv */
// Datapath of the shortest-path block: cost matrix RAM, distances, visited flags,
// fused relax-and-pick stage and output register. Depends on lssp_pkg and lssp_ram.
`default_nettype none

module lssp_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire lssp_pkg::t_cmd                 i_cmd,
    output lssp_pkg::t_sts                      o_sts,
    input  wire logic [lssp_pkg::S_TDATA_W-1:0] i_in_data,
    input  wire logic                           i_out_ready,
    output logic                                o_out_valid,
    output logic      [lssp_pkg::M_TDATA_W-1:0] o_out_data,
    output logic                                o_out_last
);

    localparam int IW = lssp_pkg::IDX_W;
    localparam int DW = lssp_pkg::DIST_W;

    // Input fields.
    logic [lssp_pkg::NODE_W-1:0] in_a, in_b, in_src;
    logic [lssp_pkg::COST_W-1:0] in_cost;
    logic                        in_ab_ok, src_ok;
    logic [IW-1:0]               src_idx;

    assign in_a     = i_in_data[lssp_pkg::A_LO +: lssp_pkg::NODE_W];
    assign in_b     = i_in_data[lssp_pkg::B_LO +: lssp_pkg::NODE_W];
    assign in_cost  = i_in_data[lssp_pkg::COST_LO +: lssp_pkg::COST_W];
    assign in_src   = i_in_data[lssp_pkg::SRC_LO +: lssp_pkg::NODE_W];
    assign in_ab_ok = lssp_pkg::node_ok(in_a) && lssp_pkg::node_ok(in_b);
    assign src_ok   = lssp_pkg::node_ok(in_src);
    assign src_idx  = IW'(in_src);

    // Held endpoints for the mirrored write.
    logic [IW-1:0]               r_a, r_b;
    logic [lssp_pkg::COST_W-1:0] r_cost;
    logic                        r_upd_ok;

    // Cost matrix.
    logic                        ram_we;
    logic [lssp_pkg::MAT_AW-1:0] ram_waddr, ram_raddr;
    logic [lssp_pkg::COST_W-1:0] ram_wdata, ram_rdata;

    // Search state.
    logic [DW-1:0]               r_dist [lssp_pkg::NODES];
    logic [lssp_pkg::NODES-1:0]  r_vis;
    logic [IW-1:0]               r_u, r_bidx;
    logic [DW-1:0]               r_du;
    logic [lssp_pkg::PICK_W-1:0] r_best;
    logic                        r_proc, r_lastk;
    logic [IW-1:0]               r_kd;

    // Output register.
    logic                        r_ovalid, r_olast;
    logic [IW-1:0]               r_oidx;
    logic [DW-1:0]               r_odist;

    // Relax-and-pick signals.
    logic [IW-1:0]               rd_idx;
    logic [DW-1:0]               dk, nd;
    logic [DW:0]                 sum;
    logic                        relax, cand;
    logic [lssp_pkg::PICK_W-1:0] best_n;
    logic [IW-1:0]               bidx_n;

    always_comb begin
        ram_we    = i_cmd.clr_we || (i_cmd.upd_ab && in_ab_ok) || (i_cmd.upd_ba && r_upd_ok);
        ram_waddr = i_cmd.clr_addr;
        ram_wdata = '0;
        if (i_cmd.upd_ab) begin
            ram_waddr = lssp_pkg::mat_addr(IW'(in_a), IW'(in_b));
            ram_wdata = in_cost;
        end else if (i_cmd.upd_ba) begin
            ram_waddr = lssp_pkg::mat_addr(r_b, r_a);
            ram_wdata = r_cost;
        end
    end

    assign ram_raddr = lssp_pkg::mat_addr(r_u, i_cmd.k);

    lssp_ram #(
        .WIDTH(lssp_pkg::COST_W),
        .DEPTH(lssp_pkg::MAT_DEPTH)
    ) u_matrix (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // The distance registers are read at one place, shared by relaxing and output.
    assign rd_idx = r_proc ? r_kd : i_cmd.k;
    assign dk     = r_dist[rd_idx];

    always_comb begin
        sum    = {1'b0, r_du} + {1'b0, ram_rdata};
        relax  = (r_du != lssp_pkg::UNREACHABLE) && !r_vis[r_kd] && (ram_rdata != '0)
                 && (sum < {1'b0, dk});
        nd     = relax ? sum[DW-1:0] : dk;
        cand   = !r_vis[r_kd] && ({(lssp_pkg::PICK_W - DW)'(0), nd} <= r_best);
        best_n = cand ? {(lssp_pkg::PICK_W - DW)'(0), nd} : r_best;
        bidx_n = cand ? r_kd : r_bidx;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd_ab) begin
            r_a      <= IW'(in_a);
            r_b      <= IW'(in_b);
            r_cost   <= in_cost;
            r_upd_ok <= in_ab_ok;
        end
        r_kd <= i_cmd.k;
        if (i_cmd.start) begin
            for (int j = 0; j < lssp_pkg::NODES; j++) begin
                r_dist[j] <= (src_ok && (src_idx == IW'(j))) ? '0 : lssp_pkg::UNREACHABLE;
            end
            // Only the first pivot starts out visited.
            r_vis  <= lssp_pkg::NODES'(1) << (src_ok ? src_idx : lssp_pkg::LAST_IDX);
            r_u    <= src_ok ? src_idx : lssp_pkg::LAST_IDX;
            r_du   <= src_ok ? '0 : lssp_pkg::UNREACHABLE;
            r_best <= lssp_pkg::PICK_LIMIT;
            r_bidx <= '0;
        end else if (r_proc) begin
            r_dist[r_kd] <= nd;
            if (r_lastk) begin
                // End of a round: the closest unvisited node becomes the next pivot.
                r_u          <= bidx_n;
                r_du         <= best_n[DW-1:0];
                r_vis[bidx_n] <= 1'b1;
                r_best       <= lssp_pkg::PICK_LIMIT;
            end else begin
                r_best <= best_n;
                r_bidx <= bidx_n;
            end
        end
        if (i_cmd.out_load) begin
            r_oidx  <= i_cmd.k;
            r_odist <= dk;
            r_olast <= (i_cmd.k == lssp_pkg::LAST_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proc   <= 1'b0;
            r_lastk  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_proc  <= i_cmd.issue;
            r_lastk <= i_cmd.issue && (i_cmd.k == lssp_pkg::LAST_IDX);
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_ovalid || i_out_ready;
    assign o_out_valid    = r_ovalid;
    assign o_out_last     = r_olast;

    always_comb begin
        o_out_data = '0;
        o_out_data[lssp_pkg::IDX_LO +: lssp_pkg::NODE_W] = lssp_pkg::NODE_W'(r_oidx);
        o_out_data[lssp_pkg::DIST_LO +: DW]              = r_odist;
    end

endmodule

`default_nettype wire

/* sv/link_state_shortest_paths.sv */
// Top level of the link-state shortest-path block: controller plus datapath.
// Depends on lssp_pkg, lssp_ctrl, lssp_dp and lssp_ram.
//
//   Channel   Dir  Beat contents
//   s_axis    in   tuser = req_type; tdata = node_a, node_b, link_cost, source_node
//   m_axis    out  tdata = node_index, distance; tlast = last
//
// After reset the block sweeps the 256-entry cost matrix to zero, one entry per cycle,
// with s_axis_tready low during the sweep. An update beat writes the matrix once
// per link direction. A compute beat loads the distances, runs NODES-1 rounds that
// each issue one matrix read per node plus one drain state for the registered read
// data, then gives NODES output beats. An m_axis stall holds the output walk; the
// last result may wait while a new beat is already accepted.
`default_nettype none

module link_state_shortest_paths (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [3:0] node_a, [7:4] node_b, [17:8] link_cost, [21:18] source_node
    input  wire logic [lssp_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] req_type
    input  wire logic                           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [3:0] node_index, [13:4] distance
    output logic      [lssp_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                                m_axis_tlast
);

    lssp_pkg::t_cmd cmd;
    lssp_pkg::t_sts sts;

    // The controller owns sequencing: clearing sweep, update writes, the relax
    // passes over the matrix row of the current pivot, and the output walk.
    lssp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_axis_tvalid),
        .i_in_kind (s_axis_tuser),
        .o_in_ready(s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    // The datapath relaxes one neighbor per cycle and tracks the closest
    // unvisited node on the fly, so the pick for the next round is ready when a
    // pass ends.
    lssp_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_in_data  (s_axis_tdata),
        .i_out_ready(m_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .o_out_data (m_axis_tdata),
        .o_out_last (m_axis_tlast)
    );

endmodule

`default_nettype wire
